/* rtl/stsg_pkg.sv */
// ----------------------------------------------------------------------------
// stsg_pkg: shared types and constants of the sine tone sample generator
// State codes, shift unit control, register indexes, sample formats and the
// elaboration-time quarter-wave sine builder.
// ----------------------------------------------------------------------------
`default_nettype none

package stsg_pkg;

	localparam int FREQ_W    = 17;
	localparam int RATE_W    = 18;
	localparam int CHAN_W    = 4;
	localparam int CH_IDX_W  = 3;
	localparam int WORD_W    = 32;
	localparam int MAG_W     = 31;
	localparam int SH_W      = FREQ_W + RATE_W;
	localparam int SCALE_W   = 63;
	localparam int CNT_W     = 6;
	localparam int MAX_CHAN  = 8;
	localparam int EXP_W     = 8;
	localparam int FRAC_W    = 23;
	localparam int MANT_W    = FRAC_W + 1;

	// float exponent of a Q1.30 magnitude: e + 127 - 30
	localparam logic [EXP_W-1:0] EXP_OFFSET = 8'd97;
	localparam logic [WORD_W-1:0] ONE_Q30   = 32'h4000_0000;
	localparam logic [63:0] HALF_PI_Q62     = 64'h6487_ED51_10B4_611A;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MOD_IDX,
		ST_MUL,
		ST_MOD_PROD,
		ST_DIV_PH,
		ST_ROM,
		ST_PREP,
		ST_SCALE,
		ST_FMT,
		ST_NORM,
		ST_PACK,
		ST_EMIT
	} state_t;

	typedef enum logic [1:0] {
		UOP_HOLD,
		UOP_LOAD,
		UOP_DIV_STEP,
		UOP_NORM_STEP
	} uop_t;

	typedef enum logic [1:0] {
		CFG_TONE_FREQ,
		CFG_SAMPLE_RATE,
		CFG_SAMPLE_FORMAT,
		CFG_CHANNEL_COUNT
	} cfg_reg_t;

	typedef enum logic [1:0] {
		FMT_U8,
		FMT_I16,
		FMT_I32,
		FMT_F32
	} sample_fmt_t;

	typedef struct packed {
		uop_t            op;
		logic            clr_rem;
		logic [SH_W-1:0] load_val;
	} unit_ctrl_t;

	// (a * b) >> s over the full 128-bit product
	function automatic logic [63:0] mul_shift(input logic [63:0] a, input logic [63:0] b,
		input int s);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		p = p >> s;
		return p[63:0];
	endfunction

	// long division of a 64-bit value by a small divisor, bit by bit
	function automatic logic [63:0] div_small(input logic [63:0] num, input logic [15:0] d);
		logic [63:0] q;
		logic [16:0] r;
		q = '0;
		r = '0;
		for (int b = 63; b >= 0; b--) begin
			r = {r[15:0], num[b]};
			if (r >= {1'b0, d}) begin
				r = r - {1'b0, d};
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	// round(sin(pi/2 * k / 2^(pb-2)) * 2^30) by a fixed-point series
	function automatic logic [63:0] quarter_sine(input logic [63:0] k, input int pb);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] sum;
		x = mul_shift(HALF_PI_Q62, k, pb - 2);
		x2 = mul_shift(x, x, 62);
		term = x;
		sum = x;
		for (int n = 1; n < 40; n++) begin
			if (term != 64'd0) begin
				term = div_small(mul_shift(term, x2, 62), 16'((2 * n) * (2 * n + 1)));
				if (n % 2 == 1)
					sum = sum - term;
				else
					sum = sum + term;
			end
		end
		return (sum + 64'h8000_0000) >> 32;
	endfunction

endpackage

`default_nettype wire

/* rtl/stsg_shift_unit.sv */
// ----------------------------------------------------------------------------
// stsg_shift_unit: shared restoring divide and normalize shift unit
// One compare-subtract per cycle for modulo and phase division, one left
// shift per cycle for float normalization.
// ----------------------------------------------------------------------------
`default_nettype none

module stsg_shift_unit #(
	parameter int QUO_W = 12
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire stsg_pkg::unit_ctrl_t          ctrl,
	input  wire logic [stsg_pkg::RATE_W-1:0]   divisor,
	output logic      [stsg_pkg::RATE_W-1:0]   rem,
	output logic      [stsg_pkg::SH_W-1:0]     sh,
	output logic      [QUO_W-1:0]              quo
);

	logic [stsg_pkg::RATE_W-1:0] rem_q;
	logic [stsg_pkg::SH_W-1:0]   sh_q;
	logic [QUO_W-1:0]            quo_q;
	logic [stsg_pkg::RATE_W:0]   trial;
	logic                        fits;
	logic [stsg_pkg::RATE_W:0]   diff;

	// partial remainder stays below divisor, so doubling fits one extra bit
	assign trial = {rem_q, sh_q[stsg_pkg::SH_W-1]};
	assign fits  = trial >= {1'b0, divisor};
	assign diff  = trial - {1'b0, divisor};

	always_ff @(posedge clk) begin
		unique case (ctrl.op)
			stsg_pkg::UOP_LOAD: begin
				sh_q <= ctrl.load_val;
				if (ctrl.clr_rem)
					rem_q <= '0;
			end
			stsg_pkg::UOP_DIV_STEP: begin
				rem_q <= fits ? diff[stsg_pkg::RATE_W-1:0] : trial[stsg_pkg::RATE_W-1:0];
				sh_q  <= {sh_q[stsg_pkg::SH_W-2:0], 1'b0};
				quo_q <= {quo_q[QUO_W-2:0], fits};
			end
			stsg_pkg::UOP_NORM_STEP: begin
				sh_q <= {sh_q[stsg_pkg::SH_W-2:0], 1'b0};
			end
			default: begin
			end
		endcase
	end

	assign rem = rem_q;
	assign sh  = sh_q;
	assign quo = quo_q;

	property p_quo_shift;
		@(posedge clk) disable iff (!arst_n)
		ctrl.op == stsg_pkg::UOP_DIV_STEP |=> quo_q[0] == $past(fits);
	endproperty
	a_quo_shift: assert property (p_quo_shift) else $error("quotient bit lost");

	property p_rem_cleared;
		@(posedge clk) disable iff (!arst_n)
		ctrl.op == stsg_pkg::UOP_LOAD && ctrl.clr_rem |=> rem_q == '0;
	endproperty
	a_rem_cleared: assert property (p_rem_cleared) else $error("remainder not cleared");

	property p_norm_keeps_rem;
		@(posedge clk) disable iff (!arst_n)
		ctrl.op == stsg_pkg::UOP_NORM_STEP |=> $stable(rem_q) && $stable(quo_q);
	endproperty
	a_norm_keeps_rem: assert property (p_norm_keeps_rem) else $error("normalize disturbed divider");

endmodule

`default_nettype wire

/* rtl/sine_tone_sample_generator.sv */
// ----------------------------------------------------------------------------
// sine_tone_sample_generator: direct digital synthesis sine tone source
// Sequencer, quarter-wave sine rom and sample formatter around one shared
// divide and shift unit.
// ----------------------------------------------------------------------------
// Usage:
// - tick channel (tick_valid, tick_stall, frame_tick): a word with frame_tick
//   set asks for one frame; a word with frame_tick clear is taken and dropped.
// - sample channel (sample_valid, sample_stall): one word per channel, the
//   same sample_word each time, channel_index counting up from 0, and
//   last_of_frame on the last one. channel_count 0 gives no words.
// - cfg channel (cfg_valid, cfg_ready, cfg_index, cfg_data): register writes,
//   taken only while the block is idle.
// - from tick to first word: index modulo, product multiply, product modulo,
//   phase quotient, rom read and prep, then scale and format for integer
//   formats; float normalizes one shift at a time and packs instead, and a
//   zero float sample goes straight to output. The divider and the float
//   normalize shift work one bit per cycle; a zero sample rate skips the
//   divider. Words then leave one per cycle while sample_stall is low.
// - tick_stall is high from the accepted tick until the last word is taken.
// - a stalled sample word holds; the block waits in its output state.
// - reset restores 600 Hz, 48000 Hz, int16, two channels and index 0.
`default_nettype none

module sine_tone_sample_generator #(
	parameter int PHASE_BITS = 12
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            tick_valid,
	output logic                                 tick_stall,
	input  wire logic                            frame_tick,
	output logic                                 sample_valid,
	input  wire logic                            sample_stall,
	output logic      [stsg_pkg::WORD_W-1:0]     sample_word,
	output logic      [stsg_pkg::CH_IDX_W-1:0]   channel_index,
	output logic                                 last_of_frame,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [1:0]                      cfg_index,
	input  wire logic [stsg_pkg::RATE_W-1:0]     cfg_data
);

	localparam int ADDR_W  = PHASE_BITS - 1;
	localparam int QUARTER = 1 << (PHASE_BITS - 2);

	typedef logic [stsg_pkg::MAG_W-1:0] sine_rom_t [QUARTER+1];

	function automatic sine_rom_t build_sine_rom();
		sine_rom_t rom;
		for (int k = 0; k <= QUARTER; k++)
			rom[k] = stsg_pkg::MAG_W'(stsg_pkg::quarter_sine(64'(k), PHASE_BITS));
		return rom;
	endfunction

	localparam sine_rom_t SINE_ROM = build_sine_rom();

	stsg_pkg::state_t state_q;
	stsg_pkg::state_t state_n;

	logic [stsg_pkg::FREQ_W-1:0] tone_freq_hz_q;
	logic [stsg_pkg::RATE_W-1:0] sample_rate_hz_q;
	stsg_pkg::sample_fmt_t       sample_format_q;
	logic [stsg_pkg::CHAN_W-1:0] channel_count_q;
	logic [stsg_pkg::RATE_W-1:0] sample_index_q;

	logic [stsg_pkg::CNT_W-1:0]    cnt_q;
	logic [stsg_pkg::CH_IDX_W-1:0] ch_q;
	logic [stsg_pkg::MAG_W-1:0]    rom_q;
	logic                          neg_q;
	logic [stsg_pkg::WORD_W-1:0]   op_q;
	logic [stsg_pkg::SCALE_W-1:0]  scale_q;
	logic [stsg_pkg::WORD_W-1:0]   word_q;

	stsg_pkg::unit_ctrl_t        unit_ctrl;
	logic [stsg_pkg::RATE_W-1:0] unit_rem;
	logic [stsg_pkg::SH_W-1:0]   unit_sh;
	logic [PHASE_BITS-1:0]       unit_quo;

	logic                        rate_zero;
	logic                        tick_go;
	logic                        word_take;
	logic [stsg_pkg::CHAN_W-1:0] chan_n;
	logic                        frame_last;
	stsg_pkg::state_t            out_next;
	logic                        is_float;

	logic [PHASE_BITS-1:0] ph;
	logic [1:0]            quad;
	logic [ADDR_W-1:0]     r_ext;
	logic [ADDR_W-1:0]     rom_addr;

	logic [stsg_pkg::RATE_W:0]    idx_inc;
	logic [stsg_pkg::SCALE_W-1:0] scale_n;
	logic [15:0]                  i16_mag;
	logic [stsg_pkg::WORD_W-1:0]  i32_mag;
	logic [stsg_pkg::WORD_W-1:0]  fmt_word;

	logic [stsg_pkg::MANT_W-1:0] mant;
	logic                        guard;
	logic                        sticky;
	logic [stsg_pkg::MANT_W:0]   mant_r;
	logic [stsg_pkg::EXP_W-1:0]  exp_f;
	logic [stsg_pkg::WORD_W-1:0] float_word;

	stsg_shift_unit #(
		.QUO_W (PHASE_BITS)
	) u_unit (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (unit_ctrl),
		.divisor (sample_rate_hz_q),
		.rem     (unit_rem),
		.sh      (unit_sh),
		.quo     (unit_quo)
	);

	assign rate_zero  = sample_rate_hz_q == '0;
	assign tick_go    = tick_valid && !tick_stall && frame_tick;
	assign word_take  = sample_valid && !sample_stall;
	assign chan_n     = (channel_count_q > stsg_pkg::CHAN_W'(stsg_pkg::MAX_CHAN))
		? stsg_pkg::CHAN_W'(stsg_pkg::MAX_CHAN) : channel_count_q;
	assign frame_last = ({1'b0, ch_q} + 4'd1) == chan_n;
	assign out_next   = (chan_n == '0) ? stsg_pkg::ST_IDLE : stsg_pkg::ST_EMIT;
	assign is_float   = sample_format_q == stsg_pkg::FMT_F32;

	// quadrant fold of the phase into a quarter-wave address
	assign ph       = rate_zero ? '0 : unit_quo;
	assign quad     = ph[PHASE_BITS-1:PHASE_BITS-2];
	assign r_ext    = {1'b0, ph[PHASE_BITS-3:0]};
	assign rom_addr = quad[0] ? (ADDR_W'(QUARTER) - r_ext) : r_ext;

	assign idx_inc = {1'b0, unit_rem} + 19'd1;

	// x * (2^k - 1) as a shift and subtract
	always_comb begin
		unique case (sample_format_q)
			stsg_pkg::FMT_U8:
				scale_n = {23'd0, op_q, 8'd0} - {31'd0, op_q};
			stsg_pkg::FMT_I16:
				scale_n = {16'd0, op_q, 15'd0} - {31'd0, op_q};
			default:
				scale_n = {op_q, 31'd0} - {31'd0, op_q};
		endcase
	end

	assign i16_mag = scale_q[45:30];
	assign i32_mag = scale_q[61:30];

	always_comb begin
		unique case (sample_format_q)
			stsg_pkg::FMT_U8:
				fmt_word = {24'd0, scale_q[38:31]};
			stsg_pkg::FMT_I16:
				fmt_word = {16'd0, neg_q ? (16'd0 - i16_mag) : i16_mag};
			default:
				fmt_word = neg_q ? (32'd0 - i32_mag) : i32_mag;
		endcase
	end

	// normalized magnitude sits at the top of the shift register
	assign mant       = unit_sh[stsg_pkg::SH_W-1 -: stsg_pkg::MANT_W];
	assign guard      = unit_sh[stsg_pkg::SH_W-1-stsg_pkg::MANT_W];
	assign sticky     = |unit_sh[stsg_pkg::SH_W-2-stsg_pkg::MANT_W:0];
	assign mant_r     = {1'b0, mant} + {24'd0, guard && (sticky || mant[0])};
	assign exp_f      = stsg_pkg::EXP_W'(cnt_q) + stsg_pkg::EXP_OFFSET
		+ {7'd0, mant_r[stsg_pkg::MANT_W]};
	assign float_word = {neg_q, exp_f, mant_r[stsg_pkg::FRAC_W-1:0]};

	// next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			stsg_pkg::ST_IDLE:
				if (tick_go)
					state_n = rate_zero ? stsg_pkg::ST_ROM : stsg_pkg::ST_MOD_IDX;
			stsg_pkg::ST_MOD_IDX:
				if (cnt_q == 6'd1)
					state_n = stsg_pkg::ST_MUL;
			stsg_pkg::ST_MUL:
				state_n = stsg_pkg::ST_MOD_PROD;
			stsg_pkg::ST_MOD_PROD:
				if (cnt_q == 6'd1)
					state_n = stsg_pkg::ST_DIV_PH;
			stsg_pkg::ST_DIV_PH:
				if (cnt_q == 6'd1)
					state_n = stsg_pkg::ST_ROM;
			stsg_pkg::ST_ROM:
				state_n = stsg_pkg::ST_PREP;
			stsg_pkg::ST_PREP:
				if (!is_float)
					state_n = stsg_pkg::ST_SCALE;
				else if (rom_q == '0)
					state_n = out_next;
				else
					state_n = stsg_pkg::ST_NORM;
			stsg_pkg::ST_SCALE:
				state_n = stsg_pkg::ST_FMT;
			stsg_pkg::ST_FMT:
				state_n = out_next;
			stsg_pkg::ST_NORM:
				if (unit_sh[stsg_pkg::SH_W-1])
					state_n = stsg_pkg::ST_PACK;
			stsg_pkg::ST_PACK:
				state_n = out_next;
			stsg_pkg::ST_EMIT:
				if (word_take && frame_last)
					state_n = stsg_pkg::ST_IDLE;
			default:
				state_n = stsg_pkg::ST_IDLE;
		endcase
	end

	// outputs and shift unit control
	always_comb begin
		tick_stall         = state_q != stsg_pkg::ST_IDLE;
		cfg_ready          = state_q == stsg_pkg::ST_IDLE;
		sample_valid       = state_q == stsg_pkg::ST_EMIT;
		unit_ctrl.op       = stsg_pkg::UOP_HOLD;
		unit_ctrl.clr_rem  = 1'b0;
		unit_ctrl.load_val = '0;
		unique case (state_q)
			stsg_pkg::ST_IDLE:
				if (tick_go && !rate_zero) begin
					unit_ctrl.op       = stsg_pkg::UOP_LOAD;
					unit_ctrl.clr_rem  = 1'b1;
					unit_ctrl.load_val = {sample_index_q, 17'd0};
				end
			stsg_pkg::ST_MOD_IDX, stsg_pkg::ST_MOD_PROD, stsg_pkg::ST_DIV_PH:
				unit_ctrl.op = stsg_pkg::UOP_DIV_STEP;
			stsg_pkg::ST_MUL: begin
				unit_ctrl.op       = stsg_pkg::UOP_LOAD;
				unit_ctrl.clr_rem  = 1'b1;
				unit_ctrl.load_val = {18'd0, tone_freq_hz_q} * {17'd0, unit_rem};
			end
			stsg_pkg::ST_PREP:
				if (is_float) begin
					unit_ctrl.op       = stsg_pkg::UOP_LOAD;
					unit_ctrl.load_val = {rom_q, 4'd0};
				end
			stsg_pkg::ST_NORM:
				if (!unit_sh[stsg_pkg::SH_W-1])
					unit_ctrl.op = stsg_pkg::UOP_NORM_STEP;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= stsg_pkg::ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tone_freq_hz_q   <= 17'd600;
			sample_rate_hz_q <= 18'd48000;
			sample_format_q  <= stsg_pkg::FMT_I16;
			channel_count_q  <= 4'd2;
			sample_index_q   <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (stsg_pkg::cfg_reg_t'(cfg_index))
					stsg_pkg::CFG_TONE_FREQ:
						tone_freq_hz_q <= cfg_data[stsg_pkg::FREQ_W-1:0];
					stsg_pkg::CFG_SAMPLE_RATE:
						sample_rate_hz_q <= cfg_data;
					stsg_pkg::CFG_SAMPLE_FORMAT:
						sample_format_q <= stsg_pkg::sample_fmt_t'(cfg_data[1:0]);
					default:
						channel_count_q <= cfg_data[stsg_pkg::CHAN_W-1:0];
				endcase
			end
			if (state_q == stsg_pkg::ST_IDLE && tick_go && rate_zero)
				sample_index_q <= '0;
			else if (state_q == stsg_pkg::ST_MUL)
				sample_index_q <= (idx_inc >= {1'b0, sample_rate_hz_q})
					? '0 : idx_inc[stsg_pkg::RATE_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			stsg_pkg::ST_IDLE:
				if (tick_go) begin
					ch_q  <= '0;
					cnt_q <= stsg_pkg::CNT_W'(stsg_pkg::RATE_W);
				end
			stsg_pkg::ST_MOD_IDX:
				cnt_q <= cnt_q - 6'd1;
			stsg_pkg::ST_MUL:
				cnt_q <= stsg_pkg::CNT_W'(stsg_pkg::SH_W);
			stsg_pkg::ST_MOD_PROD:
				cnt_q <= (cnt_q == 6'd1) ? stsg_pkg::CNT_W'(PHASE_BITS) : cnt_q - 6'd1;
			stsg_pkg::ST_DIV_PH:
				cnt_q <= cnt_q - 6'd1;
			stsg_pkg::ST_ROM: begin
				rom_q <= SINE_ROM[rom_addr];
				neg_q <= quad[1];
			end
			stsg_pkg::ST_PREP: begin
				if (sample_format_q == stsg_pkg::FMT_U8)
					op_q <= neg_q ? (stsg_pkg::ONE_Q30 - {1'b0, rom_q})
						: (stsg_pkg::ONE_Q30 + {1'b0, rom_q});
				else
					op_q <= {1'b0, rom_q};
				// exponent counts down from the Q1.30 top bit
				cnt_q <= stsg_pkg::CNT_W'(stsg_pkg::MAG_W - 1);
				if (is_float && rom_q == '0)
					word_q <= '0;
			end
			stsg_pkg::ST_SCALE:
				scale_q <= scale_n;
			stsg_pkg::ST_FMT:
				word_q <= fmt_word;
			stsg_pkg::ST_NORM:
				if (!unit_sh[stsg_pkg::SH_W-1])
					cnt_q <= cnt_q - 6'd1;
			stsg_pkg::ST_PACK:
				word_q <= float_word;
			stsg_pkg::ST_EMIT:
				if (word_take)
					ch_q <= ch_q + 3'd1;
			default: begin
			end
		endcase
	end

	assign sample_word   = word_q;
	assign channel_index = ch_q;
	assign last_of_frame = frame_last;

	property p_busy_stalls;
		@(posedge clk) disable iff (!arst_n)
		state_q != stsg_pkg::ST_IDLE |-> tick_stall && !cfg_ready;
	endproperty
	a_busy_stalls: assert property (p_busy_stalls) else $error("tick taken while busy");

	property p_next_channel;
		@(posedge clk) disable iff (!arst_n)
		sample_valid && !sample_stall && !last_of_frame |=>
			sample_valid && channel_index == 3'($past(channel_index) + 3'd1)
			&& sample_word == $past(sample_word);
	endproperty
	a_next_channel: assert property (p_next_channel) else $error("channel sequence broken");

	property p_rem_below_rate;
		@(posedge clk) disable iff (!arst_n)
		state_q == stsg_pkg::ST_MOD_PROD || state_q == stsg_pkg::ST_DIV_PH |->
			unit_rem < sample_rate_hz_q;
	endproperty
	a_rem_below_rate: assert property (p_rem_below_rate) else $error("remainder out of range");

	property p_index_wraps;
		@(posedge clk) disable iff (!arst_n)
		state_q == stsg_pkg::ST_MUL |=> sample_index_q < sample_rate_hz_q;
	endproperty
	a_index_wraps: assert property (p_index_wraps) else $error("sample index not wrapped");

	property p_float_finite;
		@(posedge clk) disable iff (!arst_n)
		state_q == stsg_pkg::ST_PACK |=> word_q[30:23] != 8'hFF;
	endproperty
	a_float_finite: assert property (p_float_finite) else $error("float word not finite");

endmodule

`default_nettype wire

/* test/sine_tone_sample_generator_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sine_tone_sample_generator_tb: self-checking bench for the sine tone source
// Feeds tick words and register writes. A local copy of the phase path,
// quarter-wave sine and format stages works out the sample words of every
// frame. Each word from the block is then compared with the oldest of them.
// Both channels idle at random, and the output side holds off once for a
// long stretch.
// ----------------------------------------------------------------------------

module sine_tone_sample_generator_tb;

	localparam int PHASE_BITS   = 12;
	localparam int QTR          = 1 << (PHASE_BITS - 2);
	localparam int DRAIN_CYCLES = 150;
	localparam int CYCLE_LIMIT  = 600000;
	localparam int RAND_TICKS   = 300;
	localparam int HOLD_CYCLES  = 400;
	localparam logic [63:0] PI_HALF_Q62 = 64'h6487_ED51_10B4_611A;

	typedef struct {
		logic [31:0] word;
		logic [2:0]  chan;
		logic        last;
	} sample_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        tick_valid = 1'b0;
	logic        tick_stall;
	logic        frame_tick = 1'b0;
	logic        sample_valid;
	logic        sample_stall = 1'b0;
	logic [31:0] sample_word;
	logic [2:0]  channel_index;
	logic        last_of_frame;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	stsg_pkg::cfg_reg_t cfg_index = stsg_pkg::CFG_TONE_FREQ;
	logic [17:0] cfg_data = '0;

	bit      tick_q[$];
	sample_t frame_words_q[$];
	longint  sine_tab [QTR+1];
	int      mismatch_cnt = 0;
	int      cycle_cnt = 0;
	logic    hold_arm = 1'b0;
	logic    hold_done = 1'b0;
	int      hold_left = 0;
	wire     calm = (cycle_cnt >= 6000) && (cycle_cnt < 12000);

	// local copy of the registers and the sample index
	logic [16:0]  tone_hz = 17'd600;
	logic [17:0]  rate_hz = 18'd48000;
	stsg_pkg::sample_fmt_t fmt_sel = stsg_pkg::FMT_I16;
	logic [3:0]   chan_cnt = 4'd2;
	logic [17:0]  frame_pos = '0;

	sine_tone_sample_generator #(
		.PHASE_BITS(PHASE_BITS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.tick_valid(tick_valid),
		.tick_stall(tick_stall),
		.frame_tick(frame_tick),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample_word(sample_word),
		.channel_index(channel_index),
		.last_of_frame(last_of_frame),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// sin(pi/2 * k/QTR) in Q1.30 from a fixed-point Taylor series
	function automatic longint quarter_sine_q30(input int k);
		logic [127:0] wide;
		logic [63:0]  x, x2, term, sum;
		wide = {64'd0, PI_HALF_Q62} * 128'(k);
		x = 64'(wide >> (PHASE_BITS - 2));
		wide = {64'd0, x} * {64'd0, x};
		x2 = 64'(wide >> 62);
		term = x;
		sum = x;
		for (int n = 1; n < 40; n++) begin
			if (term != 0) begin
				wide = {64'd0, term} * {64'd0, x2};
				term = 64'(wide >> 62) / 64'((2 * n) * (2 * n + 1));
				if (n % 2 == 1)
					sum = sum - term;
				else
					sum = sum + term;
			end
		end
		return longint'((sum + 64'h8000_0000) >> 32);
	endfunction

	// Q1.30 value to IEEE single, round to nearest even, zero as +0
	function automatic logic [31:0] q30_to_f32(input longint s);
		logic [63:0] m, rem, half, mant;
		logic        neg;
		int          e, sh;
		if (s == 0)
			return 32'd0;
		neg = (s < 0);
		m = 64'(neg ? -s : s);
		e = 0;
		while ((m >> (e + 1)) != 0)
			e++;
		if (e <= 23) begin
			mant = m << (23 - e);
		end else begin
			sh = e - 23;
			rem = m & ((64'd1 << sh) - 1);
			half = 64'd1 << (sh - 1);
			mant = m >> sh;
			if (rem > half || (rem == half && mant[0]))
				mant++;
			if ((mant >> 24) != 0) begin
				mant = mant >> 1;
				e++;
			end
		end
		return {neg, 8'(e + 97), mant[22:0]};
	endfunction

	// tick driver
	always @(posedge clk) begin
		if (!arst_n) begin
			tick_valid <= 1'b0;
		end else if (!tick_valid || !tick_stall) begin
			if (tick_q.size() != 0 && (calm || $urandom_range(99) >= 12)) begin
				tick_valid <= 1'b1;
				frame_tick <= tick_q.pop_front();
			end else begin
				tick_valid <= 1'b0;
			end
		end
	end

	// output stall, with one long hold-off once armed
	always @(posedge clk) begin
		if (hold_left != 0) begin
			sample_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_arm && !hold_done) begin
			sample_stall <= 1'b1;
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else begin
			sample_stall <= !calm && ($urandom_range(99) < 12);
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("FAIL sine_tone_sample_generator");
			$finish;
		end
	end

	// monitor: checks sample words, predicts frames, tracks register writes
	always @(posedge clk) begin
		logic [63:0] pos, prod, ph, v;
		logic [1:0]  quad;
		int          rsel, nch;
		longint      amp, mag;
		logic [31:0] word;
		sample_t     want;
		if (arst_n) begin
			if (sample_valid && !sample_stall) begin
				if (frame_words_q.size() == 0) begin
					mismatch_cnt++;
					if (mismatch_cnt <= 10)
						$display("unexpected word %h ch %0d last %0b", sample_word,
							channel_index, last_of_frame);
				end else begin
					want = frame_words_q.pop_front();
					if (want.word !== sample_word || want.chan !== channel_index ||
						want.last !== last_of_frame) begin
						mismatch_cnt++;
						if (mismatch_cnt <= 10)
							$display("mismatch: expected word %h ch %0d last %0b, got %h %0d %0b",
								want.word, want.chan, want.last, sample_word, channel_index,
								last_of_frame);
					end
				end
			end

			if (tick_valid && !tick_stall && frame_tick) begin
				ph = '0;
				if (rate_hz != 0) begin
					pos = 64'(frame_pos) % 64'(rate_hz);
					prod = (64'(tone_hz) * pos) % 64'(rate_hz);
					ph = (prod << PHASE_BITS) / 64'(rate_hz);
					frame_pos = (pos + 1 >= 64'(rate_hz)) ? 18'd0 : 18'(pos + 1);
				end else begin
					frame_pos = '0;
				end
				quad = ph[PHASE_BITS-1 -: 2];
				rsel = int'(ph[PHASE_BITS-3:0]);
				amp = sine_tab[quad[0] ? QTR - rsel : rsel];
				if (quad[1])
					amp = -amp;
				mag = (amp < 0) ? -amp : amp;
				case (fmt_sel)
					stsg_pkg::FMT_U8: begin
						word = 32'((((longint'(1) << 30) + amp) * 255) >> 31) & 32'hFF;
					end
					stsg_pkg::FMT_I16: begin
						v = (64'(mag) * 64'd32767) >> 30;
						if (amp < 0)
							v = -v;
						word = {16'd0, v[15:0]};
					end
					stsg_pkg::FMT_I32: begin
						v = (64'(mag) * 64'd2147483647) >> 30;
						if (amp < 0)
							v = -v;
						word = v[31:0];
					end
					default: begin
						word = q30_to_f32(amp);
					end
				endcase
				nch = (chan_cnt > 8) ? 8 : int'(chan_cnt);
				for (int c = 0; c < nch; c++)
					frame_words_q.push_back('{word, 3'(c), c == nch - 1});
			end

			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					stsg_pkg::CFG_TONE_FREQ:     tone_hz = cfg_data[16:0];
					stsg_pkg::CFG_SAMPLE_RATE:   rate_hz = cfg_data;
					stsg_pkg::CFG_SAMPLE_FORMAT:
						fmt_sel = stsg_pkg::sample_fmt_t'(cfg_data[1:0]);
					default:                     chan_cnt = cfg_data[3:0];
				endcase
			end
		end
	end

	// waits until every frame is out and the block has had time to go idle
	task automatic settle();
		do
			@(posedge clk);
		while (tick_q.size() != 0 || tick_valid || frame_words_q.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// leaves cfg_valid high; the caller drops it after the last write
	task automatic write_reg(input stsg_pkg::cfg_reg_t which, input logic [17:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= which;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	task automatic push_ticks(input int count);
		repeat (count) tick_q.push_back(1'b1);
	endtask

	initial begin
		int          ticks_sent;
		int          burst;
		bit          t;
		logic [17:0] val;
		for (int k = 0; k <= QTR; k++)
			sine_tab[k] = quarter_sine_q30(k);
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings, with a dropped tick in between
		tick_q.push_back(1'b1);
		tick_q.push_back(1'b0);
		tick_q.push_back(1'b1);
		settle();

		// rate 4 at 1 Hz steps through the four quadrant edges
		write_reg(stsg_pkg::CFG_TONE_FREQ, 18'd1);
		write_reg(stsg_pkg::CFG_SAMPLE_RATE, 18'd4);
		write_reg(stsg_pkg::CFG_SAMPLE_FORMAT, 18'(stsg_pkg::FMT_U8));
		write_reg(stsg_pkg::CFG_CHANNEL_COUNT, 18'd1);
		cfg_valid <= 1'b0;
		push_ticks(4);
		settle();
		write_reg(stsg_pkg::CFG_SAMPLE_FORMAT, 18'(stsg_pkg::FMT_I32));
		write_reg(stsg_pkg::CFG_CHANNEL_COUNT, 18'd8);
		cfg_valid <= 1'b0;
		push_ticks(4);
		settle();
		// channel count above eight saturates
		write_reg(stsg_pkg::CFG_SAMPLE_FORMAT, 18'(stsg_pkg::FMT_F32));
		write_reg(stsg_pkg::CFG_CHANNEL_COUNT, 18'd15);
		cfg_valid <= 1'b0;
		push_ticks(4);
		settle();
		// no channels: no words, index still moves
		write_reg(stsg_pkg::CFG_SAMPLE_FORMAT, 18'(stsg_pkg::FMT_I16));
		write_reg(stsg_pkg::CFG_CHANNEL_COUNT, 18'd0);
		cfg_valid <= 1'b0;
		push_ticks(2);
		settle();
		// zero rate pins the phase at zero
		write_reg(stsg_pkg::CFG_SAMPLE_RATE, 18'd0);
		write_reg(stsg_pkg::CFG_SAMPLE_FORMAT, 18'(stsg_pkg::FMT_F32));
		write_reg(stsg_pkg::CFG_CHANNEL_COUNT, 18'd3);
		cfg_valid <= 1'b0;
		push_ticks(2);
		settle();
		// all-ones register data, frequency masked to its width
		write_reg(stsg_pkg::CFG_TONE_FREQ, 18'h3FFFF);
		write_reg(stsg_pkg::CFG_SAMPLE_RATE, 18'h3FFFF);
		write_reg(stsg_pkg::CFG_SAMPLE_FORMAT, 18'(stsg_pkg::FMT_I32));
		write_reg(stsg_pkg::CFG_CHANNEL_COUNT, 18'd1);
		cfg_valid <= 1'b0;
		tick_q.push_back(1'b1);
		tick_q.push_back(1'b0);
		tick_q.push_back(1'b1);
		settle();

		hold_arm <= 1'b1;
		ticks_sent = 0;
		while (ticks_sent < RAND_TICKS) begin
			if ($urandom_range(9) < 7) begin
				case ($urandom_range(3))
					0:       val = 18'($urandom_range(2000));
					1:       val = 18'($urandom_range(96000));
					2:       val = 18'($urandom);
					default: val = 18'($urandom_range(15));
				endcase
				write_reg(stsg_pkg::CFG_TONE_FREQ, val);
			end
			if ($urandom_range(9) < 7) begin
				case ($urandom_range(7))
					0, 1:    val = 18'($urandom_range(1, 12));
					2:       val = 18'd0;
					3:       val = 18'd1;
					4:       val = 18'd192000;
					5:       val = 18'($urandom);
					default: val = 18'($urandom_range(8000, 96000));
				endcase
				write_reg(stsg_pkg::CFG_SAMPLE_RATE, val);
			end
			if ($urandom_range(9) < 7)
				write_reg(stsg_pkg::CFG_SAMPLE_FORMAT, 18'($urandom_range(3)));
			if ($urandom_range(9) < 7) begin
				val = ($urandom_range(9) < 8) ? 18'($urandom_range(1, 8))
					: 18'($urandom_range(15));
				write_reg(stsg_pkg::CFG_CHANNEL_COUNT, val);
			end
			cfg_valid <= 1'b0;
			burst = $urandom_range(10, 30);
			repeat (burst) begin
				t = ($urandom_range(9) != 0);
				tick_q.push_back(t);
				if (t)
					ticks_sent++;
			end
			settle();
		end

		if (mismatch_cnt == 0)
			$display("PASS sine_tone_sample_generator");
		else
			$display("FAIL sine_tone_sample_generator");
		$finish;
	end

endmodule
